FILE: rtl/hid_message_reassembler_top_defines.svh
// Assertion macros shared by the HID message reassembler checker.
`ifndef HID_MESSAGE_REASSEMBLER_TOP_DEFINES_SVH
`define HID_MESSAGE_REASSEMBLER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define HMR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hid_message_reassembler: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define HMR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hid_message_reassembler: next-cycle check failed");

`endif

FILE: rtl/hmr_pkg.sv
// Shared types and constants of the HID message reassembler.
package hmr_pkg;

	localparam int REPORT_BYTES_DEF = 64;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [0:0] REG_CHANNEL_ID = 1'd0;
	localparam logic [0:0] REG_BUFFER_CAPACITY = 1'd1;

	localparam logic [31:0] CHANNEL_ID_RESET = 32'hFFFF_FFFF;
	localparam logic [15:0] BUFFER_CAPACITY_RESET = 16'd0;

	localparam logic [7:0] TYPE_MASK = 8'h80;
	localparam logic [7:0] TYPE_INIT = 8'h80;
	localparam logic [7:0] TYPE_CONT = 8'h00;

	typedef enum logic [2:0] {
		SLOT_CHAN,
		SLOT_TYPE,
		SLOT_LEN_HI,
		SLOT_LEN_LO,
		SLOT_DATA
	} slot_t;

	typedef struct packed {
		logic       arm;
		logic       first;
		slot_t      slot;
		logic [1:0] chan_idx;
		logic [7:0] data;
	} entry_t;

endpackage

FILE: rtl/hmr_queue.sv
// Short queue of classified report bytes between the front and back parts.
module hmr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  hmr_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output hmr_pkg::entry_t head
);
	localparam int PTR_W = $clog2(hmr_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(hmr_pkg::QUEUE_DEPTH + 1);

	hmr_pkg::entry_t slots_q [hmr_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(hmr_pkg::QUEUE_DEPTH));
	assign valid   = (count_q != '0);
	assign head    = slots_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

FILE: rtl/hmr_front.sv
// Front part: accepts input transfers, tracks the report position and classifies each byte.
module hmr_front #(
	parameter int REPORT_BYTES = hmr_pkg::REPORT_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            op,
	input  logic [7:0]      data_byte,
	input  logic            first_of_report,
	output logic            push,
	output hmr_pkg::entry_t push_entry,
	input  logic            queue_full
);
	localparam int POS_W = $clog2(REPORT_BYTES + 1);

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] cur_pos;
	logic             accept;
	logic             in_range;

	assign in_stall = queue_full;
	assign accept   = in_valid && !queue_full;
	assign cur_pos  = first_of_report ? '0 : pos_q;
	assign in_range = (cur_pos < POS_W'(REPORT_BYTES));
	assign push     = accept && (op || in_range);

	always_comb begin
		push_entry.arm      = op;
		push_entry.first    = first_of_report;
		push_entry.data     = data_byte;
		push_entry.chan_idx = cur_pos[1:0];
		if (cur_pos < POS_W'(4)) begin
			push_entry.slot = hmr_pkg::SLOT_CHAN;
		end else if (cur_pos == POS_W'(4)) begin
			push_entry.slot = hmr_pkg::SLOT_TYPE;
		end else if (cur_pos == POS_W'(5)) begin
			push_entry.slot = hmr_pkg::SLOT_LEN_HI;
		end else if (cur_pos == POS_W'(6)) begin
			push_entry.slot = hmr_pkg::SLOT_LEN_LO;
		end else begin
			push_entry.slot = hmr_pkg::SLOT_DATA;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept && !op) begin
			pos_q <= in_range ? cur_pos + POS_W'(1) : cur_pos;
		end
	end

endmodule

FILE: rtl/hmr_back.sv
// Back part: frame checks, message progress, configuration registers and the result register.
module hmr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_write,
	input  logic [0:0]      cfg_index,
	input  logic [31:0]     cfg_data,
	input  logic            queue_valid,
	input  hmr_pkg::entry_t head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            byte_valid,
	output logic [7:0]      payload_byte,
	output logic [15:0]     byte_offset,
	output logic            message_done,
	output logic [15:0]     total_length,
	output logic [6:0]      command
);
	logic [31:0] channel_id_q;
	logic [15:0] capacity_q;

	logic        receiving_q, nx_receiving;
	logic        have_init_q, nx_have_init;
	logic [6:0]  cmd_q, nx_cmd;
	logic [15:0] length_q, nx_length;
	logic [15:0] recv_count_q, nx_recv_count;
	logic [6:0]  exp_seq_q, nx_exp_seq;
	logic        frame_skip_q, nx_frame_skip;
	logic        frame_is_init_q, nx_frame_is_init;
	logic [7:0]  length_high_q, nx_length_high;

	logic        res_valid;
	logic        res_byte_valid;
	logic [7:0]  res_byte;
	logic [15:0] res_offset;
	logic        res_done;
	logic [7:0]  want_byte;
	logic [15:0] recv_inc;

	logic        out_valid_q;
	logic        byte_valid_q;
	logic [7:0]  payload_byte_q;
	logic [15:0] byte_offset_q;
	logic        message_done_q;
	logic [15:0] total_length_q;
	logic [6:0]  command_q;

	assign pop      = queue_valid && (!out_valid_q || !out_stall);
	assign recv_inc = recv_count_q + 16'd1;

	always_comb begin
		case (head.chan_idx)
			2'd0:    want_byte = channel_id_q[31:24];
			2'd1:    want_byte = channel_id_q[23:16];
			2'd2:    want_byte = channel_id_q[15:8];
			default: want_byte = channel_id_q[7:0];
		endcase
	end

	always_comb begin
		nx_receiving     = receiving_q;
		nx_have_init     = have_init_q;
		nx_cmd           = cmd_q;
		nx_length        = length_q;
		nx_recv_count    = recv_count_q;
		nx_exp_seq       = exp_seq_q;
		nx_frame_skip    = frame_skip_q;
		nx_frame_is_init = frame_is_init_q;
		nx_length_high   = length_high_q;
		res_valid        = 1'b0;
		res_byte_valid   = 1'b0;
		res_byte         = 8'd0;
		res_offset       = 16'd0;
		res_done         = 1'b0;
		if (head.arm) begin
			nx_have_init     = 1'b0;
			nx_cmd           = 7'd0;
			nx_length        = 16'd0;
			nx_recv_count    = 16'd0;
			nx_exp_seq       = 7'd0;
			nx_frame_is_init = 1'b0;
			nx_length_high   = 8'd0;
			nx_receiving     = 1'b1;
			nx_frame_skip    = 1'b1;
		end else begin
			if (head.first) begin
				nx_frame_skip = 1'b0;
			end
			if (receiving_q && !nx_frame_skip) begin
				if (head.slot == hmr_pkg::SLOT_CHAN) begin
					if (head.data != want_byte) begin
						nx_frame_skip = 1'b1;
					end
				end else if (head.slot == hmr_pkg::SLOT_TYPE) begin
					if (!have_init_q) begin
						if ((head.data & hmr_pkg::TYPE_MASK) != hmr_pkg::TYPE_INIT) begin
							nx_frame_skip = 1'b1;
						end else begin
							nx_frame_is_init = 1'b1;
							nx_cmd           = head.data[6:0];
						end
					end else begin
						if (head.data != ({1'b0, exp_seq_q} | hmr_pkg::TYPE_CONT)) begin
							nx_frame_skip = 1'b1;
						end else begin
							nx_frame_is_init = 1'b0;
							nx_exp_seq       = exp_seq_q + 7'd1;
						end
					end
				end else if (frame_is_init_q && head.slot == hmr_pkg::SLOT_LEN_HI) begin
					nx_length_high = head.data;
				end else if (frame_is_init_q && head.slot == hmr_pkg::SLOT_LEN_LO) begin
					nx_length     = {length_high_q, head.data};
					nx_have_init  = 1'b1;
					nx_recv_count = 16'd0;
					nx_exp_seq    = 7'd0;
					if (nx_length == 16'd0) begin
						res_valid     = 1'b1;
						res_done      = 1'b1;
						nx_receiving  = 1'b0;
						nx_frame_skip = 1'b1;
					end
				end else if (recv_count_q < length_q) begin
					res_valid      = 1'b1;
					res_byte       = head.data;
					res_offset     = recv_count_q;
					res_byte_valid = (recv_count_q < capacity_q);
					nx_recv_count  = recv_inc;
					res_done       = (recv_inc == length_q);
					if (res_done) begin
						nx_receiving  = 1'b0;
						nx_frame_skip = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_id_q <= hmr_pkg::CHANNEL_ID_RESET;
			capacity_q   <= hmr_pkg::BUFFER_CAPACITY_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				hmr_pkg::REG_CHANNEL_ID:      channel_id_q <= cfg_data;
				hmr_pkg::REG_BUFFER_CAPACITY: capacity_q   <= cfg_data[15:0];
				default:                      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q     <= 1'b0;
			have_init_q     <= 1'b0;
			cmd_q           <= 7'd0;
			length_q        <= 16'd0;
			recv_count_q    <= 16'd0;
			exp_seq_q       <= 7'd0;
			frame_skip_q    <= 1'b0;
			frame_is_init_q <= 1'b0;
			length_high_q   <= 8'd0;
		end else if (pop) begin
			receiving_q     <= nx_receiving;
			have_init_q     <= nx_have_init;
			cmd_q           <= nx_cmd;
			length_q        <= nx_length;
			recv_count_q    <= nx_recv_count;
			exp_seq_q       <= nx_exp_seq;
			frame_skip_q    <= nx_frame_skip;
			frame_is_init_q <= nx_frame_is_init;
			length_high_q   <= nx_length_high;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && res_valid) begin
			byte_valid_q   <= res_byte_valid;
			payload_byte_q <= res_byte;
			byte_offset_q  <= res_offset;
			message_done_q <= res_done;
			total_length_q <= nx_length;
			command_q      <= nx_cmd;
		end
	end

	assign out_valid    = out_valid_q;
	assign byte_valid   = byte_valid_q;
	assign payload_byte = payload_byte_q;
	assign byte_offset  = byte_offset_q;
	assign message_done = message_done_q;
	assign total_length = total_length_q;
	assign command      = command_q;

endmodule

FILE: rtl/hid_message_reassembler_top.sv
// Top level of the HID message reassembler.
// The block takes one report byte or arm command per clock and gives at most one result per
// byte, so it sustains one transfer per cycle on both sides while the output is not stalled.
// The front part counts the byte's position in the report and classifies it as it is accepted,
// and the byte, unless past the report's end, is written into a four-entry queue at that edge.
// The back part, which holds all message state, takes the byte from the queue when the result
// register is empty or being taken and registers any result there, so a result passes the queue
// and the result register before it is offered. The input stalls only when the queue is full,
// which happens while a result waits on a stalled output. After reset the channel is broadcast
// (all ones) and the buffer capacity is zero; write the registers only while the block is idle.
module hid_message_reassembler_top #(
	parameter int REPORT_BYTES = hmr_pkg::REPORT_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [7:0]  data_byte,
	input  logic        first_of_report,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        byte_valid,
	output logic [7:0]  payload_byte,
	output logic [15:0] byte_offset,
	output logic        message_done,
	output logic [15:0] total_length,
	output logic [6:0]  command
);
	logic            push;
	hmr_pkg::entry_t push_entry;
	logic            queue_full;
	logic            queue_valid;
	logic            pop;
	hmr_pkg::entry_t head;

	hmr_front #(
		.REPORT_BYTES(REPORT_BYTES)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.data_byte      (data_byte),
		.first_of_report(first_of_report),
		.push           (push),
		.push_entry     (push_entry),
		.queue_full     (queue_full)
	);

	hmr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (queue_full),
		.pop       (pop),
		.valid     (queue_valid),
		.head      (head)
	);

	hmr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.queue_valid (queue_valid),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.byte_valid  (byte_valid),
		.payload_byte(payload_byte),
		.byte_offset (byte_offset),
		.message_done(message_done),
		.total_length(total_length),
		.command     (command)
	);

endmodule

FILE: rtl/hmr_checker.sv
// Port-level checker of the HID message reassembler and its bind.
`include "hid_message_reassembler_top_defines.svh"

module hmr_assertions (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_write,
	input logic [0:0]  cfg_index,
	input logic [31:0] cfg_data,
	input logic        in_valid,
	input logic        in_stall,
	input logic        op,
	input logic [7:0]  data_byte,
	input logic        first_of_report,
	input logic        out_valid,
	input logic        out_stall,
	input logic        byte_valid,
	input logic [7:0]  payload_byte,
	input logic [15:0] byte_offset,
	input logic        message_done,
	input logic [15:0] total_length,
	input logic [6:0]  command
);

	`HMR_ASSERT_NEXT(a_out_holds, out_valid && out_stall, out_valid)

	`HMR_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(payload_byte) && $stable(byte_offset) && $stable(total_length) && $stable(command))

	`HMR_ASSERT_NOW(a_offset_in_length, out_valid && total_length != 16'd0, byte_offset < total_length)

	`HMR_ASSERT_NOW(a_done_at_last, out_valid && message_done && total_length != 16'd0, {1'b0, byte_offset} + 17'd1 == {1'b0, total_length})

	`HMR_ASSERT_NOW(a_empty_message, out_valid && total_length == 16'd0, message_done && !byte_valid && byte_offset == 16'd0)

endmodule

bind hid_message_reassembler_top hmr_assertions u_assertions (.*);

FILE: bench/hmr_checker.sv
// Checker for the HID message reassembler: tracks its configuration, predicts every result and compares it.
`timescale 1ns / 1ps

module hmr_checker #(
	parameter int REPORT_BYTES = hmr_pkg::REPORT_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        op,
	input  logic [7:0]  data_byte,
	input  logic        first_of_report,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        byte_valid,
	input  logic [7:0]  payload_byte,
	input  logic [15:0] byte_offset,
	input  logic        message_done,
	input  logic [15:0] total_length,
	input  logic [6:0]  command,
	output int          fail_count,
	output int          pending
);
	import hmr_pkg::*;

	typedef struct packed {
		logic        valid;
		logic [7:0]  data;
		logic [15:0] offset;
		logic        done;
		logic [15:0] total;
		logic [6:0]  cmd;
	} payload_result_t;

	payload_result_t results_due[$];

	logic [31:0] chan_cfg;
	logic [15:0] cap_cfg;

	logic        receiving;
	logic        have_init;
	logic [6:0]  cmd_reg;
	logic [15:0] length_reg;
	logic [15:0] rcv_count;
	logic [6:0]  exp_seq;
	logic [6:0]  byte_pos;
	logic        skip_frame;
	logic        frame_init;
	logic [7:0]  len_hi;

	task automatic clear_progress();
		have_init = 1'b0;
		cmd_reg = '0;
		length_reg = '0;
		rcv_count = '0;
		exp_seq = '0;
		frame_init = 1'b0;
		len_hi = '0;
	endtask

	task automatic queue_result(input logic v, input logic [7:0] b, input logic [15:0] off,
			input logic dn);
		payload_result_t r;
		r.valid = v;
		r.data = b;
		r.offset = off;
		r.done = dn;
		r.total = length_reg;
		r.cmd = cmd_reg;
		results_due.push_back(r);
	endtask

	task automatic reassemble_byte(input logic o, input logic [7:0] b, input logic f);
		int pos;
		logic [7:0] want;
		logic [15:0] off;
		logic dn;
		if (o) begin
			clear_progress();
			receiving = 1'b1;
			skip_frame = 1'b1;
		end else begin
			if (f) begin
				byte_pos = '0;
				skip_frame = 1'b0;
			end
			pos = int'(byte_pos);
			if (byte_pos < REPORT_BYTES) begin
				byte_pos = byte_pos + 7'd1;
				if (receiving && !skip_frame) begin
					if (pos < 4) begin
						want = chan_cfg[(3 - pos) * 8 +: 8];
						if (b != want)
							skip_frame = 1'b1;
					end else if (pos == 4) begin
						if (!have_init) begin
							if ((b & TYPE_MASK) != TYPE_INIT) begin
								skip_frame = 1'b1;
							end else begin
								frame_init = 1'b1;
								cmd_reg = b[6:0];
							end
						end else if (b != ({1'b0, exp_seq} | TYPE_CONT)) begin
							skip_frame = 1'b1;
						end else begin
							frame_init = 1'b0;
							exp_seq = exp_seq + 7'd1;
						end
					end else if (frame_init && pos == 5) begin
						len_hi = b;
					end else if (frame_init && pos == 6) begin
						length_reg = {len_hi, b};
						have_init = 1'b1;
						rcv_count = '0;
						exp_seq = '0;
						if (length_reg == 16'd0) begin
							queue_result(1'b0, 8'd0, 16'd0, 1'b1);
							receiving = 1'b0;
							skip_frame = 1'b1;
						end
					end else if (rcv_count < length_reg) begin
						off = rcv_count;
						rcv_count = rcv_count + 16'd1;
						dn = (rcv_count == length_reg);
						queue_result(off < cap_cfg, b, off, dn);
						if (dn) begin
							receiving = 1'b0;
							skip_frame = 1'b1;
						end
					end
				end
			end
		end
	endtask

	function automatic void check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			fail_count++;
			$display("%0t ERROR: %s expected %0h actual %0h", $time, name, exp_v, act_v);
		end
	endfunction

	task automatic compare_result();
		payload_result_t e;
		if (results_due.size() == 0) begin
			fail_count++;
			$display("%0t ERROR: result transfer with none expected, offset actual %0h",
				$time, byte_offset);
		end else begin
			e = results_due.pop_front();
			check_field("byte_valid", 16'(e.valid), 16'(byte_valid));
			check_field("payload_byte", 16'(e.data), 16'(payload_byte));
			check_field("byte_offset", e.offset, byte_offset);
			check_field("message_done", 16'(e.done), 16'(message_done));
			check_field("total_length", e.total, total_length);
			check_field("command", 16'(e.cmd), 16'(command));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_progress();
			receiving = 1'b0;
			byte_pos = '0;
			skip_frame = 1'b0;
			chan_cfg = CHANNEL_ID_RESET;
			cap_cfg = BUFFER_CAPACITY_RESET;
			results_due.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_write) begin
				if (cfg_index == REG_CHANNEL_ID)
					chan_cfg = cfg_data;
				else if (cfg_index == REG_BUFFER_CAPACITY)
					cap_cfg = cfg_data[15:0];
			end
			if (out_valid && !out_stall)
				compare_result();
			if (in_valid && !in_stall)
				reassemble_byte(op, data_byte, first_of_report);
			pending = results_due.size();
		end
	end

endmodule

FILE: bench/testbench.sv
// Top of the HID message reassembler testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module testbench;
	import hmr_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 20;
	localparam int IDLE_LIMIT = 4000;
	localparam int PHASE_ITEMS = 500;

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic [0:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        op;
	logic [7:0]  data_byte;
	logic        first_of_report;
	logic        out_valid;
	logic        out_stall;
	logic        byte_valid;
	logic [7:0]  payload_byte;
	logic [15:0] byte_offset;
	logic        message_done;
	logic [15:0] total_length;
	logic [6:0]  command;
	int          fail_count;
	int          pending;

	logic        hold_req = 1'b0;
	logic        hold_ack = 1'b0;
	int          stall_pct = 0;
	int          gap_max = 0;
	int          burst_left = 0;
	int          items_sent = 0;
	logic [31:0] cur_chan;
	logic [7:0]  rep_buf [0:79];

	hid_message_reassembler_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.data_byte      (data_byte),
		.first_of_report(first_of_report),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.byte_valid     (byte_valid),
		.payload_byte   (payload_byte),
		.byte_offset    (byte_offset),
		.message_done   (message_done),
		.total_length   (total_length),
		.command        (command)
	);

	hmr_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.data_byte      (data_byte),
		.first_of_report(first_of_report),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.byte_valid     (byte_valid),
		.payload_byte   (payload_byte),
		.byte_offset    (byte_offset),
		.message_done   (message_done),
		.total_length   (total_length),
		.command        (command),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin : receiver
		int run;
		run = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != hold_ack) begin
				hold_ack = hold_req;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
			end else if (run == 0) begin
				out_stall <= ($urandom_range(99) < stall_pct);
				run = $urandom_range(1, 8);
			end else begin
				run--;
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle = 0;
			else
				idle++;
		end
		$display("Regression FAIL");
		$finish;
	end

	task automatic send_item(input logic o, input logic [7:0] d, input logic f);
		in_valid <= 1'b1;
		op <= o;
		data_byte <= d;
		first_of_report <= f;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			if (gap_max > 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, gap_max)) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
	endtask

	task automatic send_report(input int n);
		int i;
		for (i = 0; i < n; i++)
			send_item(1'b0, rep_buf[i], i == 0);
	endtask

	task automatic fill_report(input logic bad);
		int i;
		int k;
		logic [7:0] flip;
		for (i = 0; i < 80; i++)
			rep_buf[i] = 8'($urandom);
		for (i = 0; i < 4; i++)
			rep_buf[i] = cur_chan[(3 - i) * 8 +: 8];
		if (bad) begin
			k = $urandom_range(3);
			flip = 8'($urandom_range(1, 255));
			rep_buf[k] = rep_buf[k] ^ flip;
		end
	endtask

	function automatic int report_len();
		int k;
		k = $urandom_range(15);
		if (k == 0)
			return $urandom_range(65, 72);
		else if (k < 7)
			return $urandom_range(8, 63);
		return 64;
	endfunction

	task automatic drain_block();
		if (in_valid)
			in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_CHANNEL_ID)
			cur_chan = val;
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_message(input int fixed_len);
		logic [15:0] len16;
		logic [6:0]  seq;
		logic [6:0]  cmd;
		logic [6:0]  bump;
		logic        got_init;
		int rl;
		int left;
		int take;
		int frames;
		int max_frames;
		int k;
		send_item(1'b1, 8'($urandom), 1'($urandom_range(1)));
		max_frames = 1000;
		if (fixed_len >= 0) begin
			len16 = 16'(fixed_len);
		end else begin
			case ($urandom_range(9))
				0: len16 = 16'd0;
				1: len16 = 16'($urandom_range(1, 57));
				2: len16 = 16'(57 + 59 * $urandom_range(0, 2) + $urandom_range(0, 1));
				3: begin
					len16 = 16'($urandom);
					max_frames = 2;
				end
				default: len16 = 16'($urandom_range(1, 120));
			endcase
		end
		if ($urandom_range(3) == 0) begin
			// A frame that must be ignored before the init: foreign channel or continuation.
			fill_report(1'($urandom_range(1)));
			rep_buf[4] = {1'b0, rep_buf[4][6:0]};
			send_report(report_len());
		end
		fill_report(1'b0);
		cmd = 7'($urandom);
		rep_buf[4] = TYPE_INIT | {1'b0, cmd};
		rep_buf[5] = len16[15:8];
		rep_buf[6] = len16[7:0];
		rl = ($urandom_range(15) == 0) ? $urandom_range(5, 6) : report_len();
		send_report(rl);
		got_init = (rl >= 7);
		left = int'(len16);
		if (got_init) begin
			take = ((rl < 64) ? rl : 64) - 7;
			left = (take < left) ? left - take : 0;
		end
		seq = '0;
		frames = 0;
		while (got_init && left > 0 && frames < max_frames) begin
			k = $urandom_range(11);
			fill_report(k == 0);
			if (k == 1) begin
				bump = 7'($urandom_range(1, 127));
				rep_buf[4] = {1'b0, seq + bump};
			end else if (k == 2) begin
				rep_buf[4] = TYPE_INIT | {1'b0, rep_buf[4][6:0]};
			end else begin
				rep_buf[4] = TYPE_CONT | {1'b0, seq};
			end
			rl = report_len();
			send_report(rl);
			if (k > 2) begin
				seq = seq + 7'd1;
				take = ((rl < 64) ? rl : 64) - 5;
				left = (take < left) ? left - take : 0;
			end
			frames++;
		end
	endtask

	initial begin : stimulus
		int ph;
		int k;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_CHANNEL_ID;
		cfg_data = '0;
		in_valid = 1'b0;
		op = 1'b0;
		data_byte = '0;
		first_of_report = 1'b0;
		cur_chan = CHANNEL_ID_RESET;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		stall_pct = 20;
		gap_max = 3;
		write_reg(REG_CHANNEL_ID, CHANNEL_ID_RESET);
		write_reg(REG_BUFFER_CAPACITY, 32'd2);
		// Byte while idle, then an armed receive seeing a foreign channel,
		// a continuation before any init, an empty message and a short one
		// that runs past the buffer.
		send_item(1'b0, 8'h55, 1'b1);
		send_item(1'b1, 8'hFF, 1'b1);
		fill_report(1'b0);
		rep_buf[0] = 8'h00;
		send_report(2);
		fill_report(1'b0);
		rep_buf[4] = TYPE_CONT;
		send_report(5);
		fill_report(1'b0);
		rep_buf[4] = TYPE_INIT | 8'h7F;
		rep_buf[5] = 8'h00;
		rep_buf[6] = 8'h00;
		send_report(7);
		send_item(1'b1, 8'h00, 1'b0);
		fill_report(1'b0);
		rep_buf[4] = TYPE_INIT;
		rep_buf[5] = 8'h00;
		rep_buf[6] = 8'h03;
		rep_buf[7] = 8'h00;
		rep_buf[8] = 8'hFF;
		rep_buf[9] = 8'hA5;
		send_report(10);

		for (ph = 1; ph <= 4; ph++) begin
			drain_block();
			case (ph)
				1: begin
					write_reg(REG_CHANNEL_ID, 32'h0000_0000);
					write_reg(REG_BUFFER_CAPACITY, 32'h0000_FFFF);
					stall_pct = 0;
					gap_max = 0;
				end
				2: begin
					write_reg(REG_CHANNEL_ID, $urandom);
					write_reg(REG_BUFFER_CAPACITY, $urandom_range(0, 100));
					stall_pct = 30;
					gap_max = 4;
				end
				3: begin
					write_reg(REG_CHANNEL_ID, $urandom);
					write_reg(REG_BUFFER_CAPACITY, 32'd0);
					stall_pct = 70;
					gap_max = 10;
				end
				default: begin
					write_reg(REG_CHANNEL_ID, CHANNEL_ID_RESET);
					write_reg(REG_BUFFER_CAPACITY, 32'd40);
					stall_pct = 15;
					gap_max = 2;
				end
			endcase
			if (ph == 1 || ph == 3) begin
				hold_req <= ~hold_req;
				send_message($urandom_range(200, 400));
			end
			while (items_sent < ph * PHASE_ITEMS) begin
				k = $urandom_range(15);
				if (k == 0)
					repeat ($urandom_range(1, 6))
						send_item($urandom_range(15) == 0, 8'($urandom),
							1'($urandom_range(1)));
				else if (k == 1)
					drain_block();
				else
					send_message(-1);
			end
		end
		drain_block();

		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/hmr_pkg.sv
rtl/hmr_queue.sv
rtl/hmr_front.sv
rtl/hmr_back.sv
rtl/hid_message_reassembler_top.sv
rtl/hmr_checker.sv
bench/hmr_checker.sv
bench/testbench.sv
